### rtl/core/sal_pkg.sv
// Shared types and constants for the skyline atlas allocator.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
package sal_pkg;

  localparam int PAGE_WIDTH  = 128;
  localparam int PAGE_HEIGHT = 128;
  localparam int PAGE_COUNT  = 64;

  localparam int HW  = $clog2(PAGE_HEIGHT + 1);
  localparam int BW  = $clog2(PAGE_HEIGHT + 2);
  localparam int XW  = $clog2(PAGE_WIDTH);
  localparam int XCW = $clog2(PAGE_WIDTH + 1);
  localparam int PPW = $clog2(PAGE_COUNT + 1);
  localparam int PIW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ROW_BITS = PAGE_WIDTH * HW;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_BAD_DIM = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] width_req;
    logic [7:0] height_req;
  } req_t;

  typedef struct packed {
    logic [5:0] page_index;
    logic [6:0] x_pos;
    logic [6:0] y_pos;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic load;
    logic slide;
    logic scan;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOAD, S_SLIDE, S_SCAN, S_DECIDE, S_WRITE, S_FIN
  } state_t;

endpackage

### rtl/core/sal_if.sv
// Valid/ready channels for requests and results.
// Depends on sal_pkg for the payload types.
interface sal_req_if;
  logic          valid;
  logic          ready;
  sal_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sal_res_if;
  logic          valid;
  logic          ready;
  sal_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sal_cell.sv
// One column cell: holds a column height, a shifting copy and a running maximum.
// Depends on sal_pkg.
module sal_cell (
  input  logic                    clk,
  input  sal_pkg::cell_ctl_t      ctl,
  input  logic [sal_pkg::HW-1:0]  load_val,
  input  logic [sal_pkg::HW-1:0]  s_in,
  input  logic [sal_pkg::HW-1:0]  m_in,
  output logic [sal_pkg::HW-1:0]  s_out,
  output logic [sal_pkg::HW-1:0]  m_out,
  output logic [sal_pkg::HW-1:0]  c_out
);

  logic [sal_pkg::HW-1:0] c;
  logic [sal_pkg::HW-1:0] s;
  logic [sal_pkg::HW-1:0] m;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c <= load_val;
      s <= load_val;
      m <= load_val;
    end else if (ctl.slide) begin
      s <= s_in;
      m <= (s_in > m) ? s_in : m;
    end else if (ctl.scan) begin
      m <= m_in;
    end
  end

  assign s_out = s;
  assign m_out = m;
  assign c_out = c;

endmodule

### rtl/core/skyline_atlas_allocator.sv
// Skyline atlas allocator: one request at a time, one result per request.
// Per page searched: read, load, w-1 slide steps through the cell row,
// PAGE_WIDTH-w+1 scan steps and decide, plus a write on a fit; clear, bad
// size and full go straight from idle to the finish state.
// Reset (synchronous) and clear drop all page valid bits and the page pointer.
module skyline_atlas_allocator (
  input  logic          clk,
  input  logic          rst,
  sal_req_if.sink       req,
  sal_res_if.source     res
);

  localparam int PW = sal_pkg::PAGE_WIDTH;
  localparam int HW = sal_pkg::HW;

  sal_pkg::state_t state, state_next;

  logic [sal_pkg::ROW_BITS-1:0] mem [sal_pkg::PAGE_COUNT];
  logic [sal_pkg::PAGE_COUNT-1:0] row_ok;
  logic [sal_pkg::ROW_BITS-1:0] rd_row;
  logic                         rd_ok;

  logic [sal_pkg::PPW-1:0] page;
  logic [7:0]              w;
  logic [7:0]              h;
  logic [sal_pkg::BW-1:0]  best;
  logic [sal_pkg::XW-1:0]  bx;
  logic [sal_pkg::XCW-1:0] cnt;
  sal_pkg::res_t           pend;

  sal_pkg::cell_ctl_t      ctl;
  logic [HW-1:0] load_val [PW];
  logic [HW-1:0] s_sig [PW];
  logic [HW-1:0] m_sig [PW];
  logic [HW-1:0] c_sig [PW];
  logic [sal_pkg::ROW_BITS-1:0] wr_row;

  logic                    bad;
  logic                    fits;
  logic [HW-1:0]           new_h;
  logic [sal_pkg::XCW-1:0] scan_end;
  logic [sal_pkg::PIW-1:0] pi;

  assign pi = page[sal_pkg::PIW-1:0];
  assign bad = (req.data.width_req == 8'd0) || (req.data.height_req == 8'd0) ||
               (9'(req.data.width_req) > 9'(PW)) ||
               (9'(req.data.height_req) > 9'(sal_pkg::PAGE_HEIGHT));
  assign fits = (10'(best) + 10'(h)) <= 10'(sal_pkg::PAGE_HEIGHT);
  assign new_h = HW'(10'(best) + 10'(h));
  assign scan_end = sal_pkg::XCW'(10'(PW) - 10'(w));

  for (genvar i = 0; i < PW; i++) begin : g_cells
    assign load_val[i] = rd_ok ? rd_row[i*HW +: HW] : '0;
    assign wr_row[i*HW +: HW] =
      ((i >= int'(bx)) && (i < int'(bx) + int'(w))) ? new_h : c_sig[i];

    sal_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_val (load_val[i]),
      .s_in     ((i == PW - 1) ? HW'(0) : s_sig[(i + 1) % PW]),
      .m_in     ((i == PW - 1) ? HW'(0) : m_sig[(i + 1) % PW]),
      .s_out    (s_sig[i]),
      .m_out    (m_sig[i]),
      .c_out    (c_sig[i])
    );
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    ctl        = '0;
    unique case (state)
      sal_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.data.action == sal_pkg::ACT_CLEAR || bad ||
              page == sal_pkg::PPW'(sal_pkg::PAGE_COUNT)) begin
            state_next = sal_pkg::S_FIN;
          end else begin
            state_next = sal_pkg::S_READ;
          end
        end
      end
      sal_pkg::S_READ: state_next = sal_pkg::S_LOAD;
      sal_pkg::S_LOAD: begin
        ctl.load = 1'b1;
        state_next = (w == 8'd1) ? sal_pkg::S_SCAN : sal_pkg::S_SLIDE;
      end
      sal_pkg::S_SLIDE: begin
        ctl.slide = 1'b1;
        if (cnt == sal_pkg::XCW'(9'(w) - 9'd1)) state_next = sal_pkg::S_SCAN;
      end
      sal_pkg::S_SCAN: begin
        ctl.scan = 1'b1;
        if (cnt == scan_end) state_next = sal_pkg::S_DECIDE;
      end
      sal_pkg::S_DECIDE: begin
        if (fits) begin
          state_next = sal_pkg::S_WRITE;
        end else if (page == sal_pkg::PPW'(sal_pkg::PAGE_COUNT - 1)) begin
          state_next = sal_pkg::S_FIN;
        end else begin
          state_next = sal_pkg::S_READ;
        end
      end
      sal_pkg::S_WRITE: state_next = sal_pkg::S_FIN;
      sal_pkg::S_FIN: begin
        if (!res.valid || res.ready) state_next = sal_pkg::S_IDLE;
      end
      default: state_next = sal_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page      <= '0;
      row_ok    <= '0;
      res.valid <= 1'b0;
    end else begin
      if (state == sal_pkg::S_FIN && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
        res.data  <= pend;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        sal_pkg::S_IDLE: begin
          if (req.valid) begin
            w               <= req.data.width_req;
            h               <= req.data.height_req;
            pend.page_index <= '0;
            pend.x_pos      <= '0;
            pend.y_pos      <= '0;
            if (req.data.action == sal_pkg::ACT_CLEAR) begin
              page        <= '0;
              row_ok      <= '0;
              pend.status <= sal_pkg::ST_CLEARED;
            end else if (bad) begin
              pend.status <= sal_pkg::ST_BAD_DIM;
            end else begin
              pend.status <= sal_pkg::ST_FULL;
            end
          end
        end
        sal_pkg::S_READ: begin
          rd_row <= mem[pi];
          rd_ok  <= row_ok[pi];
        end
        sal_pkg::S_LOAD: begin
          cnt  <= (w == 8'd1) ? '0 : sal_pkg::XCW'(1);
          best <= sal_pkg::BW'(sal_pkg::PAGE_HEIGHT + 1);
          bx   <= '0;
        end
        sal_pkg::S_SLIDE: begin
          cnt <= (cnt == sal_pkg::XCW'(9'(w) - 9'd1)) ? '0 : cnt + 1'b1;
        end
        sal_pkg::S_SCAN: begin
          if (sal_pkg::BW'(m_sig[0]) < best) begin
            best <= sal_pkg::BW'(m_sig[0]);
            bx   <= cnt[sal_pkg::XW-1:0];
          end
          cnt <= cnt + 1'b1;
        end
        sal_pkg::S_DECIDE: begin
          if (!fits) page <= page + 1'b1;
        end
        sal_pkg::S_WRITE: begin
          mem[pi]         <= wr_row;
          row_ok[pi]      <= 1'b1;
          pend.page_index <= 6'(page);
          pend.x_pos      <= 7'(bx);
          pend.y_pos      <= 7'(best);
          pend.status     <= sal_pkg::ST_PLACED;
        end
        sal_pkg::S_FIN: ;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/sal_checker.sv
// Port-level checks for the skyline atlas allocator, bound to the top level.
// Depends on sal_pkg for status codes.
module sal_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_ready,
  input sal_pkg::res_t res_data
);

  logic zero_fields;
  assign zero_fields = (res_data.page_index == 6'd0) && (res_data.x_pos == 7'd0) &&
                       (res_data.y_pos == 7'd0);

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid) else $error("result valid right after reset");

  a_non_placed_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status != sal_pkg::ST_PLACED) |-> zero_fields)
    else $error("non-placed result carries position");

  a_placed_in_page: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == sal_pkg::ST_PLACED) |->
    (32'(res_data.page_index) < sal_pkg::PAGE_COUNT))
    else $error("placed page out of range");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind skyline_atlas_allocator sal_checker u_sal_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

### bench/skyline_atlas_checker.sv
// Checker for the skyline atlas allocator: watches the request and result channels,
// keeps its own skyline of every page and compares each result with the predicted one.
// Depends on sal_pkg and the sal_req_if / sal_res_if interfaces.
module skyline_atlas_checker (
  input  logic clk,
  input  logic rst,
  sal_req_if   req,
  sal_res_if   res,
  output int   fails,
  output int   pending
);
  import sal_pkg::*;

  logic [7:0]  skyline [PAGE_COUNT*PAGE_WIDTH];
  int unsigned open_page;
  res_t        placement_q [$];

  function automatic void wipe_atlas();
    foreach (skyline[i]) skyline[i] = '0;
    open_page = 0;
  endfunction

  function automatic res_t predict_placement(input req_t r);
    res_t        p;
    int unsigned w, h, best, best_x, top, base;
    w = r.width_req;
    h = r.height_req;
    p = '0;
    if (r.action == ACT_CLEAR) begin
      wipe_atlas();
      p.status = ST_CLEARED;
      return p;
    end
    if (w < 1 || w > PAGE_WIDTH || h < 1 || h > PAGE_HEIGHT) begin
      p.status = ST_BAD_DIM;
      return p;
    end
    while (open_page < PAGE_COUNT) begin
      base = open_page * PAGE_WIDTH;
      best = PAGE_HEIGHT + 1;
      best_x = 0;
      for (int x = 0; x + w <= PAGE_WIDTH; x++) begin
        top = 0;
        for (int k = x; k < x + w; k++)
          if (skyline[base + k] > top) top = skyline[base + k];
        if (top < best) begin
          best = top;
          best_x = x;
        end
      end
      if (best + h <= PAGE_HEIGHT) begin
        for (int k = 0; k < w; k++) skyline[base + best_x + k] = 8'(best + h);
        p.page_index = 6'(open_page);
        p.x_pos = 7'(best_x);
        p.y_pos = 7'(best);
        p.status = ST_PLACED;
        return p;
      end
      open_page++;
    end
    p.status = ST_FULL;
    return p;
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      wipe_atlas();
      placement_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (placement_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          e = placement_q.pop_front();
          if (res.data.page_index !== e.page_index) begin
            $error("page_index: expected %0d, got %0d", e.page_index, res.data.page_index);
            fails++;
          end
          if (res.data.x_pos !== e.x_pos) begin
            $error("x_pos: expected %0d, got %0d", e.x_pos, res.data.x_pos);
            fails++;
          end
          if (res.data.y_pos !== e.y_pos) begin
            $error("y_pos: expected %0d, got %0d", e.y_pos, res.data.y_pos);
            fails++;
          end
          if (res.data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, res.data.status);
            fails++;
          end
        end
      end
      if (req.valid && req.ready) placement_q.push_back(predict_placement(req.data));
    end
    pending <= placement_q.size();
  end
endmodule

### bench/skyline_atlas_allocator_tb.sv
// Top of the skyline atlas allocator bench: clock, reset, request stimulus and verdict.
// Depends on sal_pkg, the channel interfaces, the block and skyline_atlas_checker.
module skyline_atlas_allocator_tb;
  import sal_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   cycles;
  int   send_idle;
  int   recv_idle;

  sal_req_if req ();
  sal_res_if res ();

  skyline_atlas_allocator dut (.clk(clk), .rst(rst), .req(req), .res(res));

  skyline_atlas_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .res(res), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= recv_idle);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input logic act, input logic [7:0] w, input logic [7:0] h);
    req.valid <= 1'b1;
    req.data <= '{action: act, width_req: w, height_req: h};
    do @(posedge clk); while (!req.ready);
    if ($urandom_range(0, 99) < send_idle) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      send(ACT_CLEAR, 8'($urandom), 8'($urandom));
    else if (r < 4)
      send(ACT_ALLOC, 8'($urandom_range(129, 255)), 8'($urandom_range(0, 255)));
    else if (r < 6)
      send(ACT_ALLOC, 8'($urandom_range(0, 128)), 8'($urandom_range(129, 255)));
    else if (r < 7)
      send(ACT_ALLOC, 8'd0, 8'($urandom));
    else if (r < 8)
      send(ACT_ALLOC, 8'($urandom), 8'd0);
    else if (r < 14)
      send(ACT_ALLOC, 8'($urandom_range(48, 128)), 8'($urandom_range(32, 128)));
    else if (r < 24)
      send(ACT_ALLOC, 8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
    else
      send(ACT_ALLOC, 8'($urandom_range(1, 24)), 8'($urandom_range(1, 24)));
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ACT_ALLOC, 8'd1, 8'd1);
    send(ACT_ALLOC, 8'd128, 8'd1);
    send(ACT_ALLOC, 8'd1, 8'd128);
    send(ACT_ALLOC, 8'd127, 8'd3);
    send(ACT_ALLOC, 8'd0, 8'd5);
    send(ACT_ALLOC, 8'd5, 8'd0);
    send(ACT_ALLOC, 8'd129, 8'd5);
    send(ACT_ALLOC, 8'd5, 8'd129);
    send(ACT_ALLOC, 8'd255, 8'd255);
    send(ACT_CLEAR, 8'd255, 8'd255);
    send(ACT_ALLOC, 8'd128, 8'd100);
    send(ACT_ALLOC, 8'd128, 8'd50);
    send(ACT_ALLOC, 8'd1, 8'd1);
    drain();
    send(ACT_CLEAR, 8'd0, 8'd0);
    send(ACT_ALLOC, 8'd64, 8'd128);
    send(ACT_ALLOC, 8'd64, 8'd128);
    send(ACT_ALLOC, 8'd2, 8'd2);

    send(ACT_CLEAR, 8'd0, 8'd0);
    for (int i = 0; i < PAGE_COUNT; i++) send(ACT_ALLOC, 8'd128, 8'd128);
    send(ACT_ALLOC, 8'd1, 8'd1);
    send(ACT_ALLOC, 8'd128, 8'd128);
    send(ACT_CLEAR, 8'd0, 8'd0);

    send_idle = 10;
    recv_idle = 71;
    repeat (600) send_random();
    send_idle = 71;
    recv_idle = 10;
    repeat (600) send_random();
    send_idle = 0;
    recv_idle = 0;
    repeat (600) send_random();

    drain();
    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
